>>> rtl/scc_pkg.sv
// Shared types and constants for the strongly connected component counter.
package scc_pkg;

  // Fixed field widths
  localparam int EP_W  = 10;  // edge endpoint
  localparam int CNT_W = 11;  // component count and vertex_count register

  // Command codes
  localparam logic CMD_ADD_EDGE = 1'b0;
  localparam logic CMD_COMPUTE  = 1'b1;

  // Walk engine states, one-hot
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_ROOT  = 9'b000000100,
    S_FIN   = 9'b000001000,
    S_CHK   = 9'b000010000,
    S_EDGE  = 9'b000100000,
    S_VIS   = 9'b001000000,
    S_POP   = 9'b010000000,
    S_DONE  = 9'b100000000
  } walk_state_t;

  // Result handed from the walk engine to the top level
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
  } scc_done_t;

endpackage

>>> rtl/scc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/scc_walk.sv
// Kosaraju walk engine: clear sweeps, both depth-first passes, explicit stack.
module scc_walk #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096,
  localparam int VW = $clog2(MAX_VERTICES),
  localparam int NW = $clog2(MAX_VERTICES + 1),
  localparam int EW = $clog2(MAX_EDGES + 1),
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      out_free,
  input  logic [NW-1:0]             n,
  input  logic [EW-1:0]             loaded,
  output logic [AW-1:0]             edge_raddr,
  input  logic [2*scc_pkg::EP_W-1:0] edge_rd,
  output logic                      busy,
  output scc_pkg::scc_done_t        done
);

  scc_pkg::walk_state_t state, state_next;
  logic          phase, phase_next;      // 0 reversed pass, 1 forward pass
  logic [NW-1:0] idx, idx_next;          // sweep / root index
  logic [VW-1:0] root_v, root_next;
  logic [VW-1:0] cur_u, u_next;          // top of stack kept in registers
  logic [EW-1:0] cur_e, e_next;
  logic [NW-1:0] sp, sp_next;
  logic [NW-1:0] finished, fin_next;
  logic [NW-1:0] count, cnt_next;

  logic [NW-1:0] idx_dec, sp_m1, sp_m2;
  logic [EW-1:0] e_inc;
  logic [scc_pkg::EP_W-1:0] ea, eb;
  logic match;

  logic          vis_we, vis_wdata, vis_rd;
  logic [VW-1:0] vis_waddr, vis_raddr;
  logic          fin_we;
  logic [VW-1:0] fin_waddr, fin_wdata, fin_raddr, fin_rd;
  logic          stk_we;
  logic [VW-1:0] stk_waddr, stk_raddr;
  logic [VW+EW-1:0] stk_wdata, stk_rd;

  scc_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_visited (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rd)
  );

  scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_finish (
    .clk(clk), .we(fin_we), .waddr(fin_waddr), .wdata(fin_wdata),
    .raddr(fin_raddr), .rdata(fin_rd)
  );

  scc_ram #(.WIDTH(VW + EW), .DEPTH(MAX_VERTICES)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rd)
  );

  assign idx_dec = idx - 1'b1;
  assign sp_m1   = sp - 1'b1;
  assign sp_m2   = sp - NW'(2);
  assign e_inc   = cur_e + 1'b1;
  assign busy    = (state != scc_pkg::S_IDLE);

  // Edge word is {from, to}; the reversed pass swaps the roles
  assign ea = phase ? edge_rd[2*scc_pkg::EP_W-1:scc_pkg::EP_W] : edge_rd[scc_pkg::EP_W-1:0];
  assign eb = phase ? edge_rd[scc_pkg::EP_W-1:0] : edge_rd[2*scc_pkg::EP_W-1:scc_pkg::EP_W];
  assign match = (32'(ea) == 32'(cur_u)) && (32'(ea) < 32'(n)) && (32'(eb) < 32'(n));

  // Sequencer
  always_comb begin
    state_next = state;
    phase_next = phase;
    idx_next   = idx;
    root_next  = root_v;
    u_next     = cur_u;
    e_next     = cur_e;
    sp_next    = sp;
    fin_next   = finished;
    cnt_next   = count;
    vis_we     = 1'b0;
    vis_waddr  = root_v;
    vis_wdata  = 1'b0;
    vis_raddr  = root_v;
    fin_we     = 1'b0;
    fin_waddr  = finished[VW-1:0];
    fin_wdata  = cur_u;
    fin_raddr  = idx_dec[VW-1:0];
    stk_we     = 1'b0;
    stk_waddr  = sp_m1[VW-1:0];
    stk_wdata  = {cur_u, e_inc};
    stk_raddr  = sp_m2[VW-1:0];
    edge_raddr = cur_e[AW-1:0];
    done       = '0;
    case (state)
      scc_pkg::S_IDLE: begin
        if (start) begin
          phase_next = 1'b0;
          idx_next   = '0;
          fin_next   = '0;
          cnt_next   = '0;
          state_next = scc_pkg::S_CLEAR;
        end
      end
      // clear visited bits below n, one per cycle
      scc_pkg::S_CLEAR: begin
        if (idx >= n) begin
          idx_next   = phase ? finished : '0;
          state_next = scc_pkg::S_ROOT;
        end else begin
          vis_we    = 1'b1;
          vis_waddr = idx[VW-1:0];
          idx_next  = idx + 1'b1;
        end
      end
      // pick the next root candidate
      scc_pkg::S_ROOT: begin
        if (!phase) begin
          if (idx >= n) begin
            phase_next = 1'b1;
            idx_next   = '0;
            state_next = scc_pkg::S_CLEAR;
          end else begin
            vis_raddr  = idx[VW-1:0];
            root_next  = idx[VW-1:0];
            state_next = scc_pkg::S_CHK;
          end
        end else if (idx == '0) begin
          state_next = scc_pkg::S_DONE;
        end else begin
          state_next = scc_pkg::S_FIN;
        end
      end
      scc_pkg::S_FIN: begin
        root_next  = fin_rd;
        vis_raddr  = fin_rd;
        state_next = scc_pkg::S_CHK;
      end
      // start a walk from an unvisited root
      scc_pkg::S_CHK: begin
        idx_next = phase ? idx_dec : idx + 1'b1;
        if (vis_rd) begin
          state_next = scc_pkg::S_ROOT;
        end else begin
          vis_we     = 1'b1;
          vis_wdata  = 1'b1;
          u_next     = root_v;
          e_next     = '0;
          sp_next    = NW'(1);
          edge_raddr = '0;
          if (phase) begin
            cnt_next = count + 1'b1;
          end
          state_next = scc_pkg::S_EDGE;
        end
      end
      // scan one edge per cycle for the top vertex, holding on a match for the visited check
      scc_pkg::S_EDGE: begin
        if (32'(cur_e) >= 32'(loaded)) begin
          sp_next = sp_m1;
          if (!phase && (32'(finished) < MAX_VERTICES)) begin
            fin_we   = 1'b1;
            fin_next = finished + 1'b1;
          end
          if (sp == NW'(1)) begin
            state_next = scc_pkg::S_ROOT;
          end else begin
            state_next = scc_pkg::S_POP;
          end
        end else if (match) begin
          vis_raddr  = VW'(eb);
          state_next = scc_pkg::S_VIS;
        end else begin
          e_next     = e_inc;
          edge_raddr = e_inc[AW-1:0];
        end
      end
      // neighbor visited check; push when new
      scc_pkg::S_VIS: begin
        state_next = scc_pkg::S_EDGE;
        if (vis_rd) begin
          e_next     = e_inc;
          edge_raddr = e_inc[AW-1:0];
        end else begin
          vis_we    = 1'b1;
          vis_waddr = VW'(eb);
          vis_wdata = 1'b1;
          if (32'(sp) < MAX_VERTICES) begin
            stk_we     = 1'b1;
            u_next     = VW'(eb);
            e_next     = '0;
            sp_next    = sp + 1'b1;
            edge_raddr = '0;
          end else begin
            e_next     = e_inc;
            edge_raddr = e_inc[AW-1:0];
          end
        end
      end
      // reload the new top from the stack memory
      scc_pkg::S_POP: begin
        u_next     = stk_rd[VW+EW-1:EW];
        e_next     = stk_rd[EW-1:0];
        edge_raddr = stk_rd[AW-1:0];
        state_next = scc_pkg::S_EDGE;
      end
      scc_pkg::S_DONE: begin
        if (out_free) begin
          done.valid = 1'b1;
          done.count = scc_pkg::CNT_W'(count);
          state_next = scc_pkg::S_IDLE;
        end
      end
      default: state_next = scc_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= scc_pkg::S_IDLE;
      phase    <= 1'b0;
      idx      <= '0;
      sp       <= '0;
      finished <= '0;
      count    <= '0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      idx      <= idx_next;
      sp       <= sp_next;
      finished <= fin_next;
      count    <= cnt_next;
    end
    root_v <= root_next;
    cur_u  <= u_next;
    cur_e  <= e_next;
  end

  // Checks
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    32'(sp) <= MAX_VERTICES) else $error("stack depth beyond capacity");
  a_fin_bound: assert property (@(posedge clk) disable iff (rst)
    32'(finished) <= MAX_VERTICES) else $error("finish count beyond capacity");
  a_walk_stack: assert property (@(posedge clk) disable iff (rst)
    (state == scc_pkg::S_EDGE || state == scc_pkg::S_VIS) |-> sp != '0)
    else $error("edge scan with empty stack");
  a_done_count: assert property (@(posedge clk) disable iff (rst)
    done.valid |-> 32'(count) <= 32'(n)) else $error("count exceeds vertices");

endmodule

>>> rtl/strongly_connected_component_count.sv
// Top level: edge loading, vertex_count register, result register.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------------------
//  item in   | item_valid / item_ready    | command, edge_source, edge_target
//  result    | result_valid / result_ready| component_count, edges_dropped
//  config    | vertex_count_we            | vertex_count_wdata
//
// Add-edge items are taken while no compute runs; edges are written to the edge memory back to back.
// A compute on n vertices runs two clearing passes of the visited memory, root checks for
// every vertex (with a finish-list read in the second pass), and the handoff. Each walked
// vertex scans the edge memory once per pass, with a visited check for every matching
// edge and a stack reload on each return to its parent.
// Reset (rst, synchronous) empties the edge store and sets vertex_count to 1; item_ready
// is low while a compute runs, and a waiting result holds the engine at its end.
module strongly_connected_component_count_core #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic                       command,
  input  logic [scc_pkg::EP_W-1:0]   edge_source,
  input  logic [scc_pkg::EP_W-1:0]   edge_target,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [scc_pkg::CNT_W-1:0]  component_count,
  output logic                       edges_dropped,
  input  logic                       vertex_count_we,
  input  logic [scc_pkg::CNT_W-1:0]  vertex_count_wdata
);

  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  logic [scc_pkg::CNT_W-1:0] vertex_count;
  logic [NW-1:0] n;
  logic [EW-1:0] loaded;
  logic          drop_flag;
  logic          busy, accept, add_ok;
  logic [AW-1:0] edge_raddr;
  logic [2*scc_pkg::EP_W-1:0] edge_rd;
  scc_pkg::scc_done_t done;

  // Effective vertex count
  assign n = (32'(vertex_count) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vertex_count);

  assign item_ready = !busy;
  assign accept     = item_valid && item_ready;
  assign add_ok     = (32'(edge_source) < 32'(n)) && (32'(edge_target) < 32'(n))
                      && (32'(loaded) < MAX_EDGES);

  scc_ram #(.WIDTH(2 * scc_pkg::EP_W), .DEPTH(MAX_EDGES)) u_edges (
    .clk(clk),
    .we(accept && command == scc_pkg::CMD_ADD_EDGE && add_ok),
    .waddr(loaded[AW-1:0]),
    .wdata({edge_source, edge_target}),
    .raddr(edge_raddr),
    .rdata(edge_rd)
  );

  scc_walk #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_walk (
    .clk(clk),
    .rst(rst),
    .start(accept && command == scc_pkg::CMD_COMPUTE),
    .out_free(!result_valid || result_ready),
    .n(n),
    .loaded(loaded),
    .edge_raddr(edge_raddr),
    .edge_rd(edge_rd),
    .busy(busy),
    .done(done)
  );

  // Register, edge bookkeeping and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= scc_pkg::CNT_W'(1);
      loaded       <= '0;
      drop_flag    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (vertex_count_we) begin
        vertex_count <= vertex_count_wdata;
      end
      if (accept && command == scc_pkg::CMD_ADD_EDGE) begin
        if (add_ok) begin
          loaded <= loaded + 1'b1;
        end else begin
          drop_flag <= 1'b1;
        end
      end
      if (done.valid) begin
        result_valid <= 1'b1;
        loaded       <= '0;
        drop_flag    <= 1'b0;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (done.valid) begin
      component_count <= done.count;
      edges_dropped   <= drop_flag;
    end
  end

  // Checks
  a_loaded_bound: assert property (@(posedge clk) disable iff (rst)
    32'(loaded) <= MAX_EDGES) else $error("edge count beyond capacity");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !accept) else $error("item taken during compute");
  a_result_clears: assert property (@(posedge clk) disable iff (rst)
    done.valid |=> loaded == '0 && !drop_flag) else $error("edge store not emptied");

endmodule

>>> sim/scc_count_checker.sv
// Checker for the component counter: predicts results from accepted items and compares.
`timescale 1ns / 1ps

module scc_count_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  input  logic                      item_ready,
  input  logic                      command,
  input  logic [scc_pkg::EP_W-1:0]  edge_source,
  input  logic [scc_pkg::EP_W-1:0]  edge_target,
  input  logic                      result_valid,
  input  logic                      result_ready,
  input  logic [scc_pkg::CNT_W-1:0] component_count,
  input  logic                      edges_dropped,
  input  logic                      vertex_count_we,
  input  logic [scc_pkg::CNT_W-1:0] vertex_count_wdata,
  output int                        pending,
  output int                        errors,
  output int                        computes
);

  localparam int NV = 1024;
  localparam int NE = 4096;

  typedef struct {
    logic [scc_pkg::CNT_W-1:0] count;
    logic                      dropped;
  } scc_result_t;

  // Model copy of the block state
  logic [scc_pkg::EP_W-1:0]  from_mem [NE];
  logic [scc_pkg::EP_W-1:0]  to_mem   [NE];
  int                        edge_cnt;
  bit                        drop_seen;
  logic [scc_pkg::CNT_W-1:0] vcount;
  bit                        seen     [NV];
  int                        fin_list [NV];
  int                        fin_cnt;
  int                        stk_v    [NV];
  int                        stk_c    [NV];
  scc_result_t               result_q [$];
  int                        err_cnt;
  int                        comp_cnt;

  // Iterative depth-first walk; reverse follows edges backwards
  task automatic dfs(input int root, input int n, input bit reverse, input bit record);
    int sp, top, u, e, a, b;
    bit pushed;
    seen[root] = 1;
    stk_v[0] = root;
    stk_c[0] = 0;
    sp = 1;
    while (sp > 0) begin
      top = sp - 1;
      u = stk_v[top];
      e = stk_c[top];
      pushed = 0;
      while (e < edge_cnt && !pushed) begin
        a = reverse ? to_mem[e] : from_mem[e];
        b = reverse ? from_mem[e] : to_mem[e];
        e++;
        if (a == u && a < n && b < n && !seen[b]) begin
          stk_c[top] = e;
          seen[b] = 1;
          if (sp < NV) begin
            stk_v[sp] = b;
            stk_c[sp] = 0;
            sp++;
          end
          pushed = 1;
        end
      end
      if (!pushed) begin
        stk_c[top] = e;
        sp--;
        if (record && fin_cnt < NV) begin
          fin_list[fin_cnt] = u;
          fin_cnt++;
        end
      end
    end
  endtask

  // Kosaraju count over the stored edges
  function automatic int eff_n();
    return (vcount > NV) ? NV : int'(vcount);
  endfunction

  task automatic count_components(output scc_result_t res);
    int n, cnt, v;
    n = eff_n();
    cnt = 0;
    foreach (seen[i]) seen[i] = 0;
    fin_cnt = 0;
    for (int i = 0; i < n; i++)
      if (!seen[i]) dfs(i, n, 1'b1, 1'b1);
    foreach (seen[i]) seen[i] = 0;
    for (int i = fin_cnt; i > 0; i--) begin
      v = fin_list[i-1];
      if (v < n && !seen[v]) begin
        dfs(v, n, 1'b0, 1'b0);
        cnt++;
      end
    end
    res.count = cnt[scc_pkg::CNT_W-1:0];
    res.dropped = drop_seen;
    edge_cnt = 0;
    drop_seen = 0;
  endtask

  always @(posedge clk) begin
    scc_result_t r, exp_r;
    if (rst) begin
      edge_cnt = 0;
      drop_seen = 0;
      vcount = 1;
      result_q.delete();
      err_cnt = 0;
      comp_cnt = 0;
    end else begin
      if (vertex_count_we) vcount = vertex_count_wdata;
      // Observed result against the oldest prediction
      if (result_valid && result_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result count=%0d dropped=%0d", $time,
                   component_count, edges_dropped);
          err_cnt++;
        end else begin
          exp_r = result_q.pop_front();
          if (component_count !== exp_r.count) begin
            $display("%0t: component_count expected %0d actual %0d", $time,
                     exp_r.count, component_count);
            err_cnt++;
          end
          if (edges_dropped !== exp_r.dropped) begin
            $display("%0t: edges_dropped expected %0d actual %0d", $time,
                     exp_r.dropped, edges_dropped);
            err_cnt++;
          end
        end
      end
      // Accepted item
      if (item_valid && item_ready) begin
        if (command == scc_pkg::CMD_ADD_EDGE) begin
          if (edge_source >= eff_n() || edge_target >= eff_n() || edge_cnt >= NE)
            drop_seen = 1;
          else begin
            from_mem[edge_cnt] = edge_source;
            to_mem[edge_cnt] = edge_target;
            edge_cnt++;
          end
        end else begin
          count_components(r);
          result_q = {result_q, r};
          comp_cnt++;
        end
      end
    end
    pending  <= result_q.size();
    errors   <= err_cnt;
    computes <= comp_cnt;
  end

endmodule

>>> sim/tb_strongly_connected_component_count_core.sv
// Testbench top: drives graphs and compute commands into the component counter.
`timescale 1ns / 1ps

module tb_strongly_connected_component_count_core;

  logic                      clk = 0;
  logic                      rst = 1;
  logic                      item_valid = 0;
  logic                      item_ready;
  logic                      command = scc_pkg::CMD_ADD_EDGE;
  logic [scc_pkg::EP_W-1:0]  edge_source = '0;
  logic [scc_pkg::EP_W-1:0]  edge_target = '0;
  logic                      result_valid;
  logic                      result_ready = 0;
  logic [scc_pkg::CNT_W-1:0] component_count;
  logic                      edges_dropped;
  logic                      vertex_count_we = 0;
  logic [scc_pkg::CNT_W-1:0] vertex_count_wdata = '0;
  int               pending, errors, computes;
  bit               gaps_on = 1;
  int               items_sent = 0;
  int               ready_hold = 0;
  int               cur_n = 1;

  always #4 clk = ~clk;

  strongly_connected_component_count_core dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .command(command), .edge_source(edge_source), .edge_target(edge_target),
    .result_valid(result_valid), .result_ready(result_ready),
    .component_count(component_count), .edges_dropped(edges_dropped),
    .vertex_count_we(vertex_count_we), .vertex_count_wdata(vertex_count_wdata)
  );

  scc_count_checker chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .command(command), .edge_source(edge_source), .edge_target(edge_target),
    .result_valid(result_valid), .result_ready(result_ready),
    .component_count(component_count), .edges_dropped(edges_dropped),
    .vertex_count_we(vertex_count_we), .vertex_count_wdata(vertex_count_wdata),
    .pending(pending), .errors(errors), .computes(computes)
  );

  // Result side stalls in bursts
  always @(posedge clk) begin
    if (!gaps_on || rst) begin
      result_ready <= 1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      result_ready <= (ready_hold == 1);
    end else if ($urandom_range(0, 9) == 0) begin
      ready_hold <= $urandom_range(1, 16);
      result_ready <= 0;
    end else begin
      result_ready <= 1;
    end
  end

  // One item, with an optional idle burst in front
  task automatic send(input logic cmd, input logic [scc_pkg::EP_W-1:0] s,
                      input logic [scc_pkg::EP_W-1:0] t, input bit allow_gap = 1);
    if (allow_gap && gaps_on && $urandom_range(0, 7) == 0) begin
      item_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    item_valid <= 1;
    command <= cmd;
    edge_source <= s;
    edge_target <= t;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic add_edge(input int s, input int t);
    send(scc_pkg::CMD_ADD_EDGE, s[scc_pkg::EP_W-1:0], t[scc_pkg::EP_W-1:0]);
  endtask

  task automatic compute();
    send(scc_pkg::CMD_COMPUTE, scc_pkg::EP_W'($urandom()), scc_pkg::EP_W'($urandom()));
  endtask

  // Wait until the block is idle, then write vertex_count
  task automatic drain();
    item_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_vcount(input int v);
    drain();
    vertex_count_we <= 1;
    vertex_count_wdata <= v[scc_pkg::CNT_W-1:0];
    @(posedge clk);
    vertex_count_we <= 0;
    cur_n = (v > 1024) ? 1024 : v;
  endtask

  initial begin
    #200_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int n, ne, rnd_items, graphs;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty graph, self loop, range drop at reset count
    compute();
    add_edge(0, 0);
    compute();
    add_edge(1, 0);
    add_edge(0, 1023);
    compute();
    // Zero vertices: everything dropped, no components
    set_vcount(0);
    add_edge(0, 0);
    compute();
    // Full size, extreme endpoints
    set_vcount(1024);
    add_edge(1023, 0);
    add_edge(0, 1023);
    add_edge(1023, 1023);
    send(scc_pkg::CMD_COMPUTE, 10'h3ff, 10'h3ff);
    // Count above the vertex limit
    set_vcount(2047);
    add_edge(1023, 5);
    add_edge(682, 341);
    send(scc_pkg::CMD_COMPUTE, 10'h000, 10'h000);
    // Cycle plus a chain
    set_vcount(5);
    add_edge(0, 1); add_edge(1, 2); add_edge(2, 0); add_edge(3, 4);
    compute();
    // Count shrinks while edges are stored
    add_edge(0, 1); add_edge(1, 0); add_edge(3, 4); add_edge(4, 2);
    set_vcount(2);
    compute();

    // Random graphs, mostly small
    rnd_items = 0;
    graphs = 0;
    while (rnd_items < 525) begin
      if (rnd_items > 420) gaps_on = 0;
      case ($urandom_range(0, 19))
        0:       n = 1024;
        1:       n = $urandom_range(1025, 2047);
        2:       n = $urandom_range(17, 64);
        default: n = $urandom_range(1, 16);
      endcase
      if ((gaps_on && $urandom_range(0, 2) == 0) || graphs == 0) set_vcount(n);
      ne = $urandom_range(0, 20);
      for (int i = 0; i < ne; i++) begin
        if ($urandom_range(0, 9) == 0)
          add_edge($urandom_range(0, 1023), $urandom_range(0, 1023));
        else
          add_edge($urandom_range(0, cur_n - 1), $urandom_range(0, cur_n - 1));
      end
      compute();
      rnd_items += ne + 1;
      graphs++;
    end

    // Finish: wait out every result, then the tail
    drain();
    repeat (50) @(posedge clk);
    $display("Sent %0d items, %0d computes over directed, range-drop and random graphs.",
             items_sent, computes);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/scc_pkg.sv
rtl/scc_ram.sv
rtl/scc_walk.sv
rtl/strongly_connected_component_count.sv
sim/scc_count_checker.sv
sim/tb_strongly_connected_component_count_core.sv
